### hw/rtl/frame_receiver_crc16_unit_macros.svh
// Assertion macros for the framed receiver with CRC-16 check.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef FRAME_RECEIVER_CRC16_UNIT_MACROS_SVH
`define FRAME_RECEIVER_CRC16_UNIT_MACROS_SVH

// Same-cycle implication.
`define FRC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FRC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/frc_pkg.sv
// Shared types, constants and the byte-wise CRC-16 update for the frame receiver.
// No dependencies.
`timescale 1ns / 1ps

package frc_pkg;

  localparam int unsigned MaxPayloadLen = 32;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'h1021;
  localparam logic [15:0] CrcMsb  = 16'h8000;

  // Configuration register indexes (byte address = 4 * index).
  localparam logic [1:0] RegStartOne  = 2'd0;
  localparam logic [1:0] RegStartTwo  = 2'd1;
  localparam logic [1:0] RegExpVer    = 2'd2;
  localparam logic [1:0] RegCmdType   = 2'd3;

  // Result status codes.
  localparam logic [2:0] StatOk      = 3'd0;
  localparam logic [2:0] StatDesync  = 3'd1;
  localparam logic [2:0] StatLenBig  = 3'd2;
  localparam logic [2:0] StatCrcFail = 3'd3;
  localparam logic [2:0] StatBadVer  = 3'd4;
  localparam logic [2:0] StatBadType = 3'd5;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  frame_version;
    logic [7:0]  frame_kind;
    logic [7:0]  payload_length;
    logic [7:0]  sequence_number;
    logic        has_command;
    logic [15:0] command_code;
    logic        has_value;
    logic [15:0] value_field;
    logic        has_timestamp;
    logic [31:0] timestamp_us;
    logic [15:0] crc_computed;
  } frc_result_t;

  // CRC-16/CCITT-FALSE, one byte MSB first.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CrcMsb) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### hw/rtl/frame_receiver_crc16_unit.sv
// Top level of the byte-serial frame receiver with CRC-16/CCITT-FALSE check.
// Depends on frc_pkg and frame_receiver_crc16_unit_macros.svh.
`timescale 1ns / 1ps
`include "frame_receiver_crc16_unit_macros.svh"

// Takes one received byte per transaction on the input channel and follows a
// frame: start byte one, start byte two, version, type, length, sequence,
// payload and a CRC-16 sent low byte first. The CRC (poly 0x1021, init 0xFFFF,
// MSB first) covers version through the last payload byte. One result
// transaction leaves for a wrong start byte (desync), for a length above the
// maximum, and for the closing CRC byte of a frame; every other byte gives
// none. The block accepts one byte every cycle: each byte lands in an input
// register, and the whole phase step and byte-wise CRC update then run in one
// pass and load the result register, from which a result is offered on the
// output. Throughput drops below one byte per cycle only while a result sits
// unclaimed in the result register, which holds back the input register.
// Configuration (start bytes, expected version, command type) sits at byte
// addresses 0, 4, 8 and 12 of the APB port and should be written while no
// frame is in flight.
module frame_receiver_crc16_unit
  import frc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // received bytes
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  // results
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [7:0]  frame_version_o,
  output logic [7:0]  frame_kind_o,
  output logic [7:0]  payload_length_o,
  output logic [7:0]  sequence_number_o,
  output logic        has_command_o,
  output logic [15:0] command_code_o,
  output logic        has_value_o,
  output logic [15:0] value_field_o,
  output logic        has_timestamp_o,
  output logic [31:0] timestamp_us_o,
  output logic [15:0] crc_computed_o
);

  // Parser phases; unused codes fall back to waiting for start byte one.
  localparam logic [3:0] PhSof1    = 4'd0;
  localparam logic [3:0] PhSof2    = 4'd1;
  localparam logic [3:0] PhVer     = 4'd2;
  localparam logic [3:0] PhType    = 4'd3;
  localparam logic [3:0] PhLen     = 4'd4;
  localparam logic [3:0] PhSeq     = 4'd5;
  localparam logic [3:0] PhPayload = 4'd6;
  localparam logic [3:0] PhCrcl    = 4'd7;
  localparam logic [3:0] PhCrch    = 4'd8;

  localparam logic [7:0] MaxLen = 8'(MaxPayloadLen);

  // ---------------- configuration registers ----------------
  logic [7:0] sof1_q, sof2_q, exp_ver_q, cmd_type_q;
  logic       cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sof1_q     <= 8'hAA;
      sof2_q     <= 8'h55;
      exp_ver_q  <= 8'h01;
      cmd_type_q <= 8'h01;
    end else if (cfg_we) begin
      case (paddr[3:2])
        RegStartOne: sof1_q     <= pwdata[7:0];
        RegStartTwo: sof2_q     <= pwdata[7:0];
        RegExpVer:   exp_ver_q  <= pwdata[7:0];
        RegCmdType:  cmd_type_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegStartOne: prdata = {24'h0, sof1_q};
      RegStartTwo: prdata = {24'h0, sof2_q};
      RegExpVer:   prdata = {24'h0, exp_ver_q};
      RegCmdType:  prdata = {24'h0, cmd_type_q};
      default:     prdata = 32'h0;
    endcase
  end

  // ---------------- input register ----------------
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       out_valid_q;
  logic       step;

  // Advance the held byte only when the result register has room for it.
  assign step       = in_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = ~in_valid_q | step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= rx_byte_i;
    end
  end

  // ---------------- parser state ----------------
  logic [3:0]  phase_q, phase_d;
  logic [7:0]  ver_q, ver_d;
  logic [7:0]  kind_q, kind_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  seq_q, seq_d;
  logic [7:0]  pos_q, pos_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  crc_lo_q, crc_lo_d;
  logic [7:0]  head_q [8];
  logic        head_we;

  logic [15:0]  crc_next;
  logic [15:0]  rx_crc;
  logic         emit;
  frc_result_t  res_d, res_q;

  assign crc_next = crc_feed(crc_q, in_byte_q);
  assign rx_crc   = {in_byte_q, crc_lo_q};

  always_comb begin
    phase_d  = phase_q;
    ver_d    = ver_q;
    kind_d   = kind_q;
    len_d    = len_q;
    seq_d    = seq_q;
    pos_d    = pos_q;
    crc_d    = crc_q;
    crc_lo_d = crc_lo_q;
    head_we  = 1'b0;
    emit     = 1'b0;
    res_d    = '0;

    case (phase_q)
      PhSof2: begin
        if (in_byte_q == sof2_q) begin
          phase_d = PhVer;
          crc_d   = CrcInit;
        end else begin
          phase_d      = PhSof1;
          emit         = 1'b1;
          res_d.status = StatDesync;
        end
      end
      PhVer: begin
        ver_d   = in_byte_q;
        crc_d   = crc_next;
        phase_d = PhType;
      end
      PhType: begin
        kind_d  = in_byte_q;
        crc_d   = crc_next;
        phase_d = PhLen;
      end
      PhLen: begin
        len_d = in_byte_q;
        crc_d = crc_next;
        if (in_byte_q > MaxLen) begin
          phase_d      = PhSof1;
          emit         = 1'b1;
          res_d.status = StatLenBig;
        end else begin
          phase_d = PhSeq;
        end
      end
      PhSeq: begin
        seq_d   = in_byte_q;
        crc_d   = crc_next;
        pos_d   = 8'h00;
        phase_d = (len_q == 8'h00) ? PhCrcl : PhPayload;
      end
      PhPayload: begin
        // Only the first eight payload bytes are kept; the rest feed the CRC.
        head_we = (pos_q < 8'd8);
        crc_d   = crc_next;
        pos_d   = pos_q + 8'd1;
        if (pos_d >= len_q) begin
          phase_d = PhCrcl;
        end
      end
      PhCrcl: begin
        crc_lo_d = in_byte_q;
        phase_d  = PhCrch;
      end
      PhCrch: begin
        phase_d = PhSof1;
        emit    = 1'b1;
        // Check in order: CRC, then version, then type.
        if (crc_q != rx_crc) begin
          res_d.status = StatCrcFail;
        end else if (ver_q != exp_ver_q) begin
          res_d.status = StatBadVer;
        end else if (kind_q != cmd_type_q) begin
          res_d.status = StatBadType;
        end else begin
          res_d.status = StatOk;
        end
        res_d.frame_version   = ver_q;
        res_d.frame_kind      = kind_q;
        res_d.payload_length  = len_q;
        res_d.sequence_number = seq_q;
        res_d.crc_computed    = crc_q;
        if (len_q inside {8'd2, 8'd4, 8'd6, 8'd8}) begin
          res_d.has_command  = 1'b1;
          res_d.command_code = {head_q[1], head_q[0]};
        end
        if (len_q inside {8'd4, 8'd8}) begin
          res_d.has_value   = 1'b1;
          res_d.value_field = {head_q[3], head_q[2]};
        end
        if (len_q == 8'd6) begin
          res_d.has_timestamp = 1'b1;
          res_d.timestamp_us  = {head_q[5], head_q[4], head_q[3], head_q[2]};
        end else if (len_q == 8'd8) begin
          res_d.has_timestamp = 1'b1;
          res_d.timestamp_us  = {head_q[7], head_q[6], head_q[5], head_q[4]};
        end
      end
      default: begin
        // Hunt for start byte one; any other byte is a desync.
        if (in_byte_q == sof1_q) begin
          phase_d = PhSof2;
        end else begin
          phase_d      = PhSof1;
          emit         = 1'b1;
          res_d.status = StatDesync;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhSof1;
      ver_q    <= 8'h00;
      kind_q   <= 8'h00;
      len_q    <= 8'h00;
      seq_q    <= 8'h00;
      pos_q    <= 8'h00;
      crc_q    <= CrcInit;
      crc_lo_q <= 8'h00;
    end else if (step) begin
      phase_q  <= phase_d;
      ver_q    <= ver_d;
      kind_q   <= kind_d;
      len_q    <= len_d;
      seq_q    <= seq_d;
      pos_q    <= pos_d;
      crc_q    <= crc_d;
      crc_lo_q <= crc_lo_d;
    end
  end

  // Payload head bytes: written by the frame before they are decoded.
  always_ff @(posedge clk_i) begin
    if (step && head_we) begin
      head_q[pos_q[2:0]] <= in_byte_q;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && emit) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = res_q.status;
  assign frame_version_o   = res_q.frame_version;
  assign frame_kind_o      = res_q.frame_kind;
  assign payload_length_o  = res_q.payload_length;
  assign sequence_number_o = res_q.sequence_number;
  assign has_command_o     = res_q.has_command;
  assign command_code_o    = res_q.command_code;
  assign has_value_o       = res_q.has_value;
  assign value_field_o     = res_q.value_field;
  assign has_timestamp_o   = res_q.has_timestamp;
  assign timestamp_us_o    = res_q.timestamp_us;
  assign crc_computed_o    = res_q.crc_computed;

  // ---------------- assertions ----------------
  `FRC_ASSERT_NOW(a_no_step_when_blocked, out_valid_q && !out_ready_i, !step, "byte advanced into a held result")
  `FRC_ASSERT_NEXT(a_close_returns_hunt, step && phase_q == PhCrch, phase_q == PhSof1, "closing byte did not return to hunt")
  `FRC_ASSERT_NOW(a_pos_below_len, phase_q == PhPayload, pos_q < len_q, "payload position ran past length")
  `FRC_ASSERT_NOW(a_value_needs_cmd, out_valid_q && res_q.has_value, res_q.has_command, "value without command")
  `FRC_ASSERT_NOW(a_desync_zero, out_valid_q && res_q.status == StatDesync, res_q.crc_computed == 16'h0 && res_q.payload_length == 8'h0, "desync result carries frame data")

endmodule
